// ===== design/tsf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths, register codes, rounding and elaboration helpers for the tape saturation stage.
package tsf_pkg;

    // Datapath widths fixed by the Q formats of the registers and the internal Q.23 values.
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 21;
    localparam int ACC_W   = 48;
    localparam int DRV_W   = 26;
    localparam int U_W     = 27;
    localparam int ST_W    = 24;
    localparam int TANH_W  = 24;
    localparam int COEF_W  = 16;
    localparam int CFG_INDEX_W = 4;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BETA  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIX   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE = 4'd3;

    localparam logic [COEF_W-1:0] ALPHA_RST = 16'd786;
    localparam logic [COEF_W-1:0] BETA_RST  = 16'd1704;
    localparam logic [COEF_W-1:0] MIX_RST   = 16'd19661;
    localparam logic [COEF_W-1:0] DRIVE_RST = 16'd15729;

    // Limits of the Q1.23 channel state.
    localparam logic signed [ACC_W-1:0] ST_HI = 48'sd8388607;
    localparam logic signed [ACC_W-1:0] ST_LO = -48'sd8388608;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DRV,
        ST_BETA,
        ST_DRVW,
        ST_INNER,
        ST_TL0,
        ST_TL1,
        ST_TL2,
        ST_TL3,
        ST_TL4,
        ST_ST0,
        ST_ST1,
        ST_ST2,
        ST_ST3,
        ST_MX0,
        ST_MX1,
        ST_MX2,
        ST_Y0,
        ST_Y1,
        ST_Y2,
        ST_Y3
    } tsf_state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        OPA_X23,
        OPA_STATE,
        OPA_DIFF,
        OPA_TANH,
        OPA_DRIVEN
    } opa_sel_t;

    typedef enum logic [2:0] {
        OPB_GAIN,
        OPB_BETA,
        OPB_FRAC,
        OPB_ALPHA,
        OPB_ALPHA_C,
        OPB_MIX,
        OPB_MIX_C
    } opb_sel_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

    typedef struct packed {
        mac_ctrl_t mac;
        opa_sel_t  a_sel;
        opb_sel_t  b_sel;
        logic      in_ready;
        logic      ld_st;
        logic      ld_driven;
        logic      ld_u_inner;
        logic      ld_u_outer;
        logic      rom_hi;
        logic      ld_t0;
        logic      ld_tanh;
        logic      wr_state;
        logic      ld_out;
    } seq_ctrl_t;

    // Round half up: floor((v + 2^(n-1)) / 2^n), for n of one or more.
    function automatic logic signed [ACC_W-1:0] tsf_rnd(input logic signed [ACC_W-1:0] v,
                                                         input int unsigned n);
        logic signed [ACC_W-1:0] half;
        logic signed [ACC_W-1:0] sum;
        half = '0;
        half[n-1] = 1'b1;
        sum = v + half;
        return sum >>> n;
    endfunction

    // Restoring long division, used only while the tanh table is built at elaboration.
    function automatic logic [63:0] tsf_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

endpackage

// ===== design/tape_saturation_feedback_stage.sv =====
`timescale 1ns / 1ps
// Top level of the tape saturation feedback stage: registers, datapath and channel state.
//
// Each accepted sample is processed to completion before the next is taken: its result
// appears on m_valid in the same cycle that s_ready returns. The output register holds one
// finished result while the next sample is worked on, and the last step of that sample
// waits until the previous result has been taken. The work is done by one shared
// multiply-accumulate unit, which a sequencer steps through nine products, and by two tanh
// lookups that each read the single-port table twice and interpolate. Channel states reset
// to zero at once; there is no clearing pass. Configuration writes are always accepted and
// must only be made while no sample is in flight; writes to unknown indexes are ignored.
module tape_saturation_feedback_stage
    import tsf_pkg::*;
#(
    parameter int CHANNELS        = 2,
    parameter int SAMPLE_BITS     = 16,
    parameter int TANH_TABLE_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                          s_channel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [COEF_W-1:0]             cfg_data
);

    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TBL_N     = 1 << TANH_TABLE_BITS;
    localparam int AW        = TANH_TABLE_BITS + 1;
    localparam int IDX_SHIFT = 25 - TANH_TABLE_BITS;
    localparam int X_SHIFT   = 24 - SAMPLE_BITS;
    localparam logic signed [31:0] OUT_HI = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
    localparam logic signed [31:0] OUT_LO = -(32'sd1 <<< (SAMPLE_BITS - 1));

    seq_ctrl_t ctrl;
    logic      in_fire;
    logic      out_free;

    // Configuration registers.
    logic [COEF_W-1:0] alpha_reg;
    logic [COEF_W-1:0] beta_reg;
    logic [COEF_W-1:0] mix_reg;
    logic [COEF_W-1:0] drive_reg;

    // Sample in flight and its intermediate values.
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [CH_IDX_W-1:0]           ch_reg;
    logic [CH_IDX_W-1:0]           ch_next;
    logic signed [ST_W-1:0]        st_reg;
    logic signed [ST_W-1:0]        chan_st_reg [CHANNELS];
    logic signed [DRV_W-1:0]       driven_reg;
    logic signed [U_W-1:0]         u_reg;
    logic [TANH_W-1:0]             t0_reg;
    logic signed [TANH_W-1:0]      tanh_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic                          m_valid_reg;
    logic                          m_valid_next;

    logic signed [ST_W-1:0]    x23;
    logic signed [ACC_W-1:0]   acc;
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;

    // Table lookup fields taken from the tanh argument.
    logic                       u_neg;
    logic [U_W-1:0]             u_abs;
    logic                       u_clip;
    logic [TANH_TABLE_BITS-1:0] u_idx;
    logic [IDX_SHIFT-1:0]       u_frac;
    logic [AW-1:0]              lo_addr;
    logic [AW-1:0]              hi_addr;
    logic [AW-1:0]              rom_addr;
    logic [TANH_W-1:0]          rom_data;
    logic [TANH_W-1:0]          t_mag;

    logic signed [ACC_W-1:0] st_full;
    logic signed [ST_W-1:0]  st_sat;
    logic signed [31:0]      y32;
    logic signed [31:0]      y_sh;
    logic signed [31:0]      y_sat;

    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = ctrl.in_ready;
    assign cfg_ready = 1'b1;

    tsf_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    tsf_mac u_mac (
        .aclk (aclk),
        .ctrl (ctrl.mac),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    tsf_tanh_rom #(
        .TANH_TABLE_BITS (TANH_TABLE_BITS)
    ) u_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RST;
            beta_reg  <= BETA_RST;
            mix_reg   <= MIX_RST;
            drive_reg <= DRIVE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ALPHA: alpha_reg <= cfg_data;
                REG_BETA:  beta_reg  <= cfg_data;
                REG_MIX:   mix_reg   <= cfg_data;
                REG_DRIVE: drive_reg <= cfg_data;
                default:   alpha_reg <= alpha_reg;
            endcase
        end
    end

    // A channel number beyond the configured count uses the last channel.
    always_comb begin
        if (32'(s_channel) >= 32'(CHANNELS)) begin
            ch_next = CH_IDX_W'(CHANNELS - 1);
        end else begin
            ch_next = CH_IDX_W'(s_channel);
        end
    end

    assign x23 = ST_W'(sample_reg) <<< X_SHIFT;

    always_comb begin
        u_neg   = u_reg[U_W-1];
        u_abs   = u_neg ? U_W'(-u_reg) : U_W'(u_reg);
        u_clip  = |u_abs[U_W-1:25];
        u_idx   = u_abs[24 -: TANH_TABLE_BITS];
        u_frac  = u_clip ? '0 : u_abs[IDX_SHIFT-1:0];
        lo_addr = u_clip ? AW'(TBL_N) : AW'(u_idx);
        hi_addr = u_clip ? AW'(TBL_N) : AW'(u_idx) + AW'(1);
        rom_addr = ctrl.rom_hi ? hi_addr : lo_addr;
    end

    always_comb begin
        case (ctrl.a_sel)
            OPA_X23:    op_a = MUL_A_W'(x23);
            OPA_STATE:  op_a = MUL_A_W'(st_reg);
            OPA_DIFF:   op_a = signed'(MUL_A_W'(rom_data)) - signed'(MUL_A_W'(t0_reg));
            OPA_TANH:   op_a = MUL_A_W'(tanh_reg);
            OPA_DRIVEN: op_a = MUL_A_W'(driven_reg);
            default:    op_a = '0;
        endcase
    end

    always_comb begin
        case (ctrl.b_sel)
            OPB_GAIN:    op_b = signed'(MUL_B_W'(drive_reg));
            OPB_BETA:    op_b = signed'(MUL_B_W'(beta_reg));
            OPB_FRAC:    op_b = signed'(MUL_B_W'(u_frac));
            OPB_ALPHA:   op_b = signed'(MUL_B_W'(alpha_reg));
            OPB_ALPHA_C: op_b = signed'(MUL_B_W'(17'h10000 - {1'b0, alpha_reg}));
            OPB_MIX:     op_b = signed'(MUL_B_W'(mix_reg));
            OPB_MIX_C:   op_b = signed'(MUL_B_W'(17'h10000 - {1'b0, mix_reg}));
            default:     op_b = '0;
        endcase
    end

    // Interpolated magnitude; the accumulator holds the slope times the fraction.
    assign t_mag = t0_reg + TANH_W'(tsf_rnd(acc, IDX_SHIFT));

    always_comb begin
        st_full = tsf_rnd(acc, 16);
        if (st_full > ST_HI) begin
            st_sat = ST_W'(ST_HI);
        end else if (st_full < ST_LO) begin
            st_sat = ST_W'(ST_LO);
        end else begin
            st_sat = ST_W'(st_full);
        end
    end

    assign y32 = 32'(tsf_rnd(acc, 16));

    generate
        if (X_SHIFT > 0) begin : g_out_round
            assign y_sh = 32'(tsf_rnd(ACC_W'(y32), X_SHIFT));
        end else begin : g_out_plain
            assign y_sh = y32;
        end
    endgenerate

    always_comb begin
        if (y_sh > OUT_HI) begin
            y_sat = OUT_HI;
        end else if (y_sh < OUT_LO) begin
            y_sat = OUT_LO;
        end else begin
            y_sat = y_sh;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            sample_reg <= s_sample_in;
            ch_reg     <= ch_next;
        end
        if (ctrl.ld_st) begin
            st_reg <= chan_st_reg[ch_reg];
        end else if (ctrl.wr_state) begin
            st_reg <= st_sat;
        end
        if (ctrl.ld_driven) begin
            driven_reg <= DRV_W'(tsf_rnd(acc, 14));
        end
        if (ctrl.ld_u_inner) begin
            u_reg <= U_W'(driven_reg) - U_W'(tsf_rnd(acc, 16));
        end else if (ctrl.ld_u_outer) begin
            u_reg <= U_W'(driven_reg) + U_W'(tsf_rnd(acc, 16));
        end
        if (ctrl.ld_t0) begin
            t0_reg <= rom_data;
        end
        if (ctrl.ld_tanh) begin
            tanh_reg <= u_neg ? -signed'(t_mag) : signed'(t_mag);
        end
        if (ctrl.ld_out) begin
            out_reg <= SAMPLE_BITS'(y_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                chan_st_reg[i] <= '0;
            end
        end else if (ctrl.wr_state) begin
            chan_st_reg[ch_reg] <= st_sat;
        end
    end

    // The result is held until the transaction on the output completes.
    always_comb begin
        if (ctrl.ld_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;

endmodule

// ===== design/tsf_tanh_rom.sv =====
`timescale 1ns / 1ps
// Constant tanh table over [0, 4] in Q.23 with a registered read port.
module tsf_tanh_rom
    import tsf_pkg::*;
#(
    parameter int TANH_TABLE_BITS = 8
) (
    input  logic                       aclk,
    input  logic [TANH_TABLE_BITS:0]   rd_addr,
    output logic [TANH_W-1:0]          rd_data
);

    localparam int TBL_N = 1 << TANH_TABLE_BITS;

    typedef logic [TANH_W-1:0] tbl_t [0:TBL_N];

    // Entry k is tanh(4k/2^TANH_TABLE_BITS), built from a Taylor estimate of the step
    // exponential and a running product, all in integer arithmetic.
    function automatic tbl_t build_tbl();
        tbl_t        t;
        logic [63:0] h;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] one;
        logic [63:0] num;
        logic [63:0] den;
        h    = 64'd1 << (27 - TANH_TABLE_BITS);
        one  = 64'd1 << 24;
        term = one;
        r    = one;
        e    = one;
        for (int n = 1; n <= 10; n++) begin
            term = tsf_udiv((term * h) >> 24, 64'(n));
            r = r + term;
        end
        for (int k = 0; k <= TBL_N; k++) begin
            num  = (e - one) << 23;
            den  = e + one;
            t[k] = TANH_W'(tsf_udiv(num + (den >> 1), den));
            e    = (e * r + (64'd1 << 23)) >> 24;
        end
        return t;
    endfunction

    localparam tbl_t TANH_TBL = build_tbl();

    logic [TANH_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= TANH_TBL[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/tsf_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: registered product followed by a registered accumulator.
module tsf_mac
    import tsf_pkg::*;
(
    input  logic                       aclk,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [MUL_A_W-1:0]  op_a,
    input  logic signed [MUL_B_W-1:0]  op_b,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign prod_next = ACC_W'(op_a) * ACC_W'(op_b);

    always_comb begin
        case (ctrl.acc_op)
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== design/tsf_seq.sv =====
`timescale 1ns / 1ps
// Sequencer that steps the shared multiply-accumulate unit and the tanh lookup for one sample.
module tsf_seq
    import tsf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  logic      out_free,
    output seq_ctrl_t ctrl
);

    tsf_state_t state_reg;
    tsf_state_t state_next;
    // Low during the lookup for the state update, high during the one for the output.
    logic       pass_reg;
    logic       pass_next;

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_DRV;
                end
            end
            ST_DRV:   state_next = ST_BETA;
            ST_BETA:  state_next = ST_DRVW;
            ST_DRVW:  state_next = ST_INNER;
            ST_INNER: begin
                state_next = ST_TL0;
                pass_next  = 1'b0;
            end
            ST_TL0: state_next = ST_TL1;
            ST_TL1: state_next = ST_TL2;
            ST_TL2: state_next = ST_TL3;
            ST_TL3: state_next = ST_TL4;
            ST_TL4: state_next = pass_reg ? ST_Y0 : ST_ST0;
            ST_ST0: state_next = ST_ST1;
            ST_ST1: state_next = ST_ST2;
            ST_ST2: state_next = ST_ST3;
            ST_ST3: state_next = ST_MX0;
            ST_MX0: state_next = ST_MX1;
            ST_MX1: state_next = ST_MX2;
            ST_MX2: begin
                state_next = ST_TL0;
                pass_next  = 1'b1;
            end
            ST_Y0: state_next = ST_Y1;
            ST_Y1: state_next = ST_Y2;
            ST_Y2: state_next = ST_Y3;
            ST_Y3: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        ctrl.mac.acc_op = ACC_HOLD;
        ctrl.a_sel = OPA_X23;
        ctrl.b_sel = OPB_GAIN;
        case (state_reg)
            ST_IDLE: ctrl.in_ready = 1'b1;
            ST_DRV: begin
                ctrl.a_sel      = OPA_X23;
                ctrl.b_sel      = OPB_GAIN;
                ctrl.mac.mul_en = 1'b1;
                ctrl.ld_st      = 1'b1;
            end
            ST_BETA: begin
                ctrl.a_sel      = OPA_STATE;
                ctrl.b_sel      = OPB_BETA;
                ctrl.mac.mul_en = 1'b1;
                ctrl.mac.acc_op = ACC_LOAD;
            end
            ST_DRVW: begin
                ctrl.mac.acc_op = ACC_LOAD;
                ctrl.ld_driven  = 1'b1;
            end
            ST_INNER: ctrl.ld_u_inner = 1'b1;
            ST_TL0:   ctrl.rom_hi = 1'b0;
            ST_TL1: begin
                ctrl.ld_t0  = 1'b1;
                ctrl.rom_hi = 1'b1;
            end
            ST_TL2: begin
                ctrl.a_sel      = OPA_DIFF;
                ctrl.b_sel      = OPB_FRAC;
                ctrl.mac.mul_en = 1'b1;
            end
            ST_TL3: ctrl.mac.acc_op = ACC_LOAD;
            ST_TL4: ctrl.ld_tanh = 1'b1;
            ST_ST0: begin
                ctrl.a_sel      = OPA_STATE;
                ctrl.b_sel      = OPB_ALPHA_C;
                ctrl.mac.mul_en = 1'b1;
            end
            ST_ST1: begin
                ctrl.a_sel      = OPA_TANH;
                ctrl.b_sel      = OPB_ALPHA;
                ctrl.mac.mul_en = 1'b1;
                ctrl.mac.acc_op = ACC_LOAD;
            end
            ST_ST2: ctrl.mac.acc_op = ACC_ADD;
            ST_ST3: ctrl.wr_state = 1'b1;
            ST_MX0: begin
                ctrl.a_sel      = OPA_STATE;
                ctrl.b_sel      = OPB_MIX;
                ctrl.mac.mul_en = 1'b1;
            end
            ST_MX1: ctrl.mac.acc_op = ACC_LOAD;
            ST_MX2: ctrl.ld_u_outer = 1'b1;
            ST_Y0: begin
                ctrl.a_sel      = OPA_DRIVEN;
                ctrl.b_sel      = OPB_MIX_C;
                ctrl.mac.mul_en = 1'b1;
            end
            ST_Y1: begin
                ctrl.a_sel      = OPA_TANH;
                ctrl.b_sel      = OPB_MIX;
                ctrl.mac.mul_en = 1'b1;
                ctrl.mac.acc_op = ACC_LOAD;
            end
            ST_Y2: ctrl.mac.acc_op = ACC_ADD;
            ST_Y3: ctrl.ld_out = out_free;
            default: ctrl.in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the tape saturation feedback stage, with its own prediction.
module tb_top
    import tsf_pkg::*;
;

    localparam int SAMPLE_W       = 16;
    localparam int LUT_BITS       = 8;
    localparam int LUT_LAST       = 1 << LUT_BITS;
    localparam int FRAC_BITS      = 25 - LUT_BITS;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 250;
    localparam int MAX_REPORTS    = 50;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       channel;
    } sample_txn_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [SAMPLE_W-1:0]   s_sample_in = '0;
    logic                         s_channel = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]   m_sample_out;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [COEF_W-1:0]            cfg_data = '0;

    // Mirror of the coefficient registers and the per-channel feedback state.
    logic [COEF_W-1:0]            coef_alpha;
    logic [COEF_W-1:0]            coef_beta;
    logic [COEF_W-1:0]            coef_mix;
    logic [COEF_W-1:0]            coef_drive;
    logic signed [ST_W-1:0]       chan_state [2];
    longint                       tanh_lut [0:LUT_LAST];

    sample_txn_t                  pending_samples[$];
    logic signed [SAMPLE_W-1:0]   expected_samples[$];

    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned src_idle_chance = 0;
    int unsigned sink_idle_chance = 0;
    int unsigned quiet_cycles = 0;
    int unsigned error_count = 0;
    int unsigned samples_sent = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned settings_used = 0;
    sample_txn_t                  drv_next;
    logic signed [SAMPLE_W-1:0]   want;

    tape_saturation_feedback_stage dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .s_channel    (s_channel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint round_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // tanh(4k/256) in Q.23, from an exponential series built in integer arithmetic only.
    function automatic void build_tanh_lut();
        longint unsigned step;
        longint unsigned term;
        longint unsigned ratio;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned unity;
        step  = 64'd1 << (27 - LUT_BITS);
        unity = 64'd1 << 24;
        term  = unity;
        ratio = unity;
        e     = unity;
        for (int n = 1; n <= 10; n++) begin
            term = (term * step) / (64'(n) << 24);
            ratio = ratio + term;
        end
        for (int k = 0; k <= LUT_LAST; k++) begin
            num = (e - unity) << 23;
            den = e + unity;
            tanh_lut[k] = longint'((num + den / 2) / den);
            e = (e * ratio + (64'd1 << 23)) >> 24;
        end
    endfunction

    function automatic longint tanh_interp(input longint u);
        longint mag;
        longint idx;
        longint frac;
        longint t;
        mag = (u < 0) ? -u : u;
        idx = mag >>> FRAC_BITS;
        if (idx >= LUT_LAST) begin
            t = tanh_lut[LUT_LAST];
        end else begin
            frac = mag & ((64'sd1 <<< FRAC_BITS) - 1);
            t = tanh_lut[idx] + round_shift((tanh_lut[idx + 1] - tanh_lut[idx]) * frac,
                                            FRAC_BITS);
        end
        return (u < 0) ? -t : t;
    endfunction

    // Works out one output sample and advances the selected channel's feedback state.
    function automatic logic signed [SAMPLE_W-1:0] tape_predict(
        input logic signed [SAMPLE_W-1:0] x, input logic ch);
        longint driven;
        longint st;
        longint inner;
        longint outer;
        longint y;
        longint a;
        longint b;
        longint m;
        a = longint'(coef_alpha);
        b = longint'(coef_beta);
        m = longint'(coef_mix);
        driven = round_shift((longint'(x) <<< (24 - SAMPLE_W)) * longint'(coef_drive), 14);
        st = longint'(chan_state[ch]);
        inner = driven - round_shift(b * st, 16);
        st = round_shift((65536 - a) * st + a * tanh_interp(inner), 16);
        st = clamp(st, -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1);
        chan_state[ch] = st[ST_W-1:0];
        outer = driven + round_shift(m * st, 16);
        y = round_shift((65536 - m) * driven + m * tanh_interp(outer), 16);
        y = round_shift(y, 24 - SAMPLE_W);
        y = clamp(y, -(64'sd1 <<< (SAMPLE_W - 1)), (64'sd1 <<< (SAMPLE_W - 1)) - 1);
        return y[SAMPLE_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what);
        if (error_count < MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    // Source side: holds each transaction until it is taken, idles in short bursts.
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            expected_samples.push_back(tape_predict(s_sample_in, s_channel));
            samples_sent++;
        end
        if (!s_valid || s_ready) begin
            if (src_gap != 0) begin
                s_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (pending_samples.size() != 0 && src_idle_chance != 0 &&
                         $urandom_range(0, 15) < src_idle_chance) begin
                s_valid <= 1'b0;
                src_gap <= $urandom_range(0, 3);
            end else if (pending_samples.size() != 0) begin
                drv_next = pending_samples.pop_front();
                s_valid <= 1'b1;
                s_sample_in <= drv_next.sample;
                s_channel <= drv_next.channel;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: checks every transaction against the oldest prediction.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %0d", m_sample_out));
            end else begin
                want = expected_samples.pop_front();
                if (m_sample_out !== want) begin
                    flag_mismatch($sformatf("sample_out %0d, expected %0d",
                                            m_sample_out, want));
                end
                results_checked++;
            end
        end
        if (sink_gap != 0) begin
            m_ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (sink_idle_chance != 0 && $urandom_range(0, 15) < sink_idle_chance) begin
            m_ready <= 1'b0;
            sink_gap <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ALPHA: coef_alpha = val;
            REG_BETA:  coef_beta = val;
            REG_MIX:   coef_mix = val;
            REG_DRIVE: coef_drive = val;
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_coefs(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
                             input logic [COEF_W-1:0] m, input logic [COEF_W-1:0] d);
        write_reg(REG_ALPHA, a);
        write_reg(REG_BETA, b);
        write_reg(REG_MIX, m);
        write_reg(REG_DRIVE, d);
        settings_used++;
    endtask

    // Waits until the block has nothing in flight, so that registers may be written.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_samples.size() != 0 || s_valid || expected_samples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] v, input logic ch);
        sample_txn_t t;
        t.sample = v;
        t.channel = ch;
        pending_samples.push_back(t);
    endtask

    initial begin
        logic signed [SAMPLE_W-1:0] v;
        build_tanh_lut();
        coef_alpha = ALPHA_RST;
        coef_beta = BETA_RST;
        coef_mix = MIX_RST;
        coef_drive = DRIVE_RST;
        chan_state[0] = '0;
        chan_state[1] = '0;
        settings_used = 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset coefficients: rails, zero, smallest steps and a sustained full-scale run.
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd32767, 1'b0);
        push_sample(-16'sd32768, 1'b0);
        push_sample(16'sd32767, 1'b1);
        push_sample(-16'sd32768, 1'b1);
        push_sample(16'sd1, 1'b0);
        push_sample(-16'sd1, 1'b1);
        push_sample(16'sd16384, 1'b0);
        push_sample(-16'sd16384, 1'b1);
        repeat (4) push_sample(16'sd32767, 1'b0);
        wait_drained();

        // Full drive with no blend: the output clips.
        write_reg(CFG_INDEX_W'($urandom_range(REG_DRIVE + 1, (1 << CFG_INDEX_W) - 1)),
                  COEF_W'($urandom_range(0, 65535)));
        set_coefs(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        push_sample(16'sd32767, 1'b0);
        push_sample(-16'sd32768, 1'b1);
        push_sample(16'sd12000, 1'b0);
        push_sample(-16'sd12000, 1'b1);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd8192, 1'b1);
        push_sample(-16'sd8192, 1'b0);
        push_sample(16'sd100, 1'b1);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: set_coefs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: set_coefs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000);
                6: set_coefs(ALPHA_RST, BETA_RST, MIX_RST, DRIVE_RST);
                default: set_coefs(COEF_W'($urandom_range(0, 65535)),
                                   COEF_W'($urandom_range(0, 65535)),
                                   COEF_W'($urandom_range(0, 65535)),
                                   COEF_W'($urandom_range(0, 65535)));
            endcase
            // Idle pressure varies by phase; the final phase runs flat out.
            if (phase == RANDOM_PHASES - 1) begin
                src_idle_chance = 0;
                sink_idle_chance = 0;
            end else begin
                src_idle_chance = (phase % 3 == 0) ? 4 : ((phase % 3 == 1) ? 15 : 0);
                sink_idle_chance = (phase % 3 == 0) ? 15 : ((phase % 3 == 1) ? 0 : 4);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: v = SAMPLE_W'($urandom_range(0, 4095) - 2048);
                    2:    v = ($urandom_range(0, 1) != 0)
                              ? SAMPLE_W'(16'sd32767 - $urandom_range(0, 15))
                              : SAMPLE_W'(-16'sd32768 + $urandom_range(0, 15));
                    default: v = SAMPLE_W'($urandom_range(0, 65535));
                endcase
                push_sample(v, 1'($urandom_range(0, 1)));
            end
            wait_drained();
        end

        $display("Sent %0d samples over %0d coefficient settings with %0d register writes;",
                 samples_sent, settings_used, reg_writes);
        $display("checked %0d results, %0d mismatches.", results_checked, error_count);
        if (error_count == 0 && expected_samples.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tsf_pkg.sv
design/tsf_tanh_rom.sv
design/tsf_mac.sv
design/tsf_seq.sv
design/tape_saturation_feedback_stage.sv
tb/tb_top.sv
